@@ hw/rtl/ps2md_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types, constants and helper functions of the PS/2 mouse decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

    localparam int BYTE_W      = 8;
    localparam int SCREEN_W    = 13;
    localparam int POS_W       = 12;
    localparam int DX_W        = 9;
    localparam int DY_W        = 10;
    localparam int BTN_W       = 3;
    localparam int DIFF_W      = DY_W + 1;
    localparam int SUM_W       = POS_W + 2;
    localparam int M_TDATA_W   = 48;

    localparam logic [7:0] ACK_BYTE   = 8'hFA;
    localparam logic [7:0] HDR_MASK   = 8'hC8;
    localparam logic [7:0] HDR_MATCH  = 8'h08;
    localparam int         HDR_XSIGN  = 4;
    localparam int         HDR_YSIGN  = 5;

    localparam logic [SCREEN_W-1:0] CURSOR_SIZE  = 13'd16;
    localparam logic [SCREEN_W-1:0] TASKBAR_ROWS = 13'd28;
    localparam logic [SCREEN_W-1:0] Y_OFFSET     = CURSOR_SIZE + TASKBAR_ROWS;
    localparam logic [SCREEN_W-1:0] POS_MAX      = 13'd4095;
    localparam logic signed [DIFF_W-1:0] JUMP_LIMIT = 11'sd50;

    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd320;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd200;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_WAIT_ACK = 4'b0001,
        PH_HEADER   = 4'b0010,
        PH_X_BYTE   = 4'b0100,
        PH_Y_BYTE   = 4'b1000
    } phase_t;

    // buttons sits in the lowest bits
    typedef struct packed {
        logic [POS_W-1:0]        cursor_y;
        logic [POS_W-1:0]        cursor_x;
        logic signed [DY_W-1:0]  delta_y;
        logic signed [DX_W-1:0]  delta_x;
        logic [BTN_W-1:0]        buttons;
    } result_t;

    // start position: (screen - off) / 2, zero when the screen is too small
    function automatic logic [POS_W-1:0] centre_of(input logic [SCREEN_W-1:0] screen,
                                                   input logic [SCREEN_W-1:0] off);
        logic [SCREEN_W-1:0] diff;
        diff = screen - off;
        if (screen < off) begin
            return '0;
        end
        return diff[SCREEN_W-1:1];
    endfunction

    // upper clamp bound: screen - cursor size, saturated to the coordinate range
    function automatic logic [POS_W-1:0] bound_of(input logic [SCREEN_W-1:0] screen);
        logic [SCREEN_W-1:0] diff;
        diff = screen - CURSOR_SIZE;
        if (screen < CURSOR_SIZE) begin
            return '0;
        end
        if (diff > POS_MAX) begin
            return POS_MAX[POS_W-1:0];
        end
        return diff[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] move_clamp(input logic [POS_W-1:0] pos,
                                                    input logic signed [DY_W-1:0] delta,
                                                    input logic [POS_W-1:0] hi);
        logic signed [SUM_W-1:0] sum;
        sum = $signed({2'b00, pos}) + SUM_W'(delta);
        if (sum < 0) begin
            return '0;
        end
        if (sum > $signed({2'b00, hi})) begin
            return hi;
        end
        return sum[POS_W-1:0];
    endfunction

    function automatic logic is_near(input logic signed [DY_W-1:0] a,
                                     input logic signed [DY_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return (d < JUMP_LIMIT) && (d > -JUMP_LIMIT);
    endfunction

endpackage

@@ hw/rtl/ps2md_in_reg.sv @@
// ----------------------------------------------------------------------------
// ps2md_in_reg
// Input register: holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module ps2md_in_reg
    import ps2md_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              in_take,
    output logic              in_valid,
    output logic [BYTE_W-1:0] in_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready = !valid_reg || in_take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg && !in_take;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

@@ hw/rtl/ps2md_decode.sv @@
// ----------------------------------------------------------------------------
// ps2md_decode
// Packet framing, jump filter, cursor update and screen size registers.
// ----------------------------------------------------------------------------
module ps2md_decode
    import ps2md_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [SCREEN_W-1:0] cfg_wdata,
    input  logic                in_valid,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                out_free,
    output logic                in_take,
    output logic                res_valid,
    output result_t             res
);

    phase_t                  phase_reg, phase_next;
    logic [BYTE_W-1:0]       header_reg, header_next;
    logic [BYTE_W-1:0]       xbyte_reg, xbyte_next;
    logic signed [DY_W-1:0]  prev_dx_reg, prev_dx_next;
    logic signed [DY_W-1:0]  prev_dy_reg, prev_dy_next;
    logic [POS_W-1:0]        pos_x_reg, pos_x_next;
    logic [POS_W-1:0]        pos_y_reg, pos_y_next;
    logic [SCREEN_W-1:0]     width_reg, width_next;
    logic [SCREEN_W-1:0]     height_reg, height_next;

    logic signed [DX_W-1:0]  dx;
    logic signed [DX_W-1:0]  dy_raw;
    logic signed [DY_W-1:0]  dx_ext;
    logic signed [DY_W-1:0]  dy;
    logic                    pass;
    logic [POS_W-1:0]        new_x;
    logic [POS_W-1:0]        new_y;

    assign in_take = in_valid && out_free;

    always_comb begin
        dx     = $signed({header_reg[HDR_XSIGN], xbyte_reg});
        dy_raw = $signed({header_reg[HDR_YSIGN], in_byte});
        dx_ext = DY_W'(dx);
        dy     = -DY_W'(dy_raw);
        pass   = is_near(dx_ext, prev_dx_reg) && is_near(dy, prev_dy_reg);
        new_x  = move_clamp(pos_x_reg, dx_ext, bound_of(width_reg));
        new_y  = move_clamp(pos_y_reg, dy, bound_of(height_reg));
    end

    always_comb begin
        phase_next   = phase_reg;
        header_next  = header_reg;
        xbyte_next   = xbyte_reg;
        prev_dx_next = prev_dx_reg;
        prev_dy_next = prev_dy_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        res_valid    = 1'b0;

        res.buttons  = header_reg[BTN_W-1:0];
        res.delta_x  = dx;
        res.delta_y  = dy;
        res.cursor_x = new_x;
        res.cursor_y = new_y;

        if (in_take) begin
            unique case (phase_reg)
                PH_WAIT_ACK: begin
                    if (in_byte == ACK_BYTE) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if ((in_byte & HDR_MASK) == HDR_MATCH) begin
                        header_next = in_byte;
                        phase_next  = PH_X_BYTE;
                    end
                end
                PH_X_BYTE: begin
                    xbyte_next = in_byte;
                    phase_next = PH_Y_BYTE;
                end
                PH_Y_BYTE: begin
                    phase_next = PH_HEADER;
                    if (pass) begin
                        prev_dx_next = dx_ext;
                        prev_dy_next = dy;
                        pos_x_next   = new_x;
                        pos_y_next   = new_y;
                        res_valid    = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_WAIT_ACK;
                end
            endcase
        end

        // writes must come only while idle, which the block does not enforce; both axes recentre on either register
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SCREEN_WIDTH:  width_next  = cfg_wdata;
                REG_SCREEN_HEIGHT: height_next = cfg_wdata;
                default:           width_next  = width_reg;
            endcase
            pos_x_next = centre_of(width_next, CURSOR_SIZE);
            pos_y_next = centre_of(height_next, Y_OFFSET);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_WAIT_ACK;
            header_reg  <= '0;
            xbyte_reg   <= '0;
            prev_dx_reg <= '0;
            prev_dy_reg <= '0;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            pos_x_reg   <= centre_of(WIDTH_RESET, CURSOR_SIZE);
            pos_y_reg   <= centre_of(HEIGHT_RESET, Y_OFFSET);
        end else begin
            phase_reg   <= phase_next;
            header_reg  <= header_next;
            xbyte_reg   <= xbyte_next;
            prev_dx_reg <= prev_dx_next;
            prev_dy_reg <= prev_dy_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
        end
    end

endmodule

@@ hw/rtl/ps2md_out_reg.sv @@
// ----------------------------------------------------------------------------
// ps2md_out_reg
// Result register: holds one decoded packet until the sink takes it.
// ----------------------------------------------------------------------------
module ps2md_out_reg
    import ps2md_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    input  result_t              res,
    output logic                 out_free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(result_t))'(0), data_reg};

    always_comb begin
        valid_next = valid_reg && !m_tready;
        if (res_valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            data_reg <= res;
        end
    end

endmodule

@@ hw/rtl/ps2_mouse_decoder_with_cursor.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_decoder_with_cursor
// Frames PS/2 mouse bytes into packets, filters jumps and tracks a cursor.
// ----------------------------------------------------------------------------
// channel  | ports                     | item
// s_       | s_tvalid s_tready s_tdata | one mouse byte
// m_       | m_tvalid m_tready m_tdata | buttons, deltas, cursor of a packet
// cfg_     | cfg_wr_en cfg_index       | screen width (0), screen height (1)
//
// one byte per cycle unless the output stalls; a byte waits in the input
// register, then the decoder writes the packet's result into the output register.
// the cursor adder and clamp in the decoder set the single-cycle path.
// reset (aresetn low, synchronous) empties both registers, waits for the
// acknowledge byte and centres the cursor on a 320 by 200 screen.
// while m_tready is low the output holds; one more byte is taken and kept.
// ----------------------------------------------------------------------------
module ps2_mouse_decoder_with_cursor
    import ps2md_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,    // data_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // buttons[2:0], delta_x[11:3], delta_y[21:12], cursor_x[33:22],
    // cursor_y[45:34], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_index,
    input  logic [SCREEN_W-1:0]  cfg_wdata
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_take;
    logic              out_free;
    logic              res_valid;
    result_t           res;

    ps2md_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .in_take  (in_take),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    ps2md_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .out_free  (out_free),
        .in_take   (in_take),
        .res_valid (res_valid),
        .res       (res)
    );

    ps2md_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ hw/rtl/ps2md_checker.sv @@
// ----------------------------------------------------------------------------
// ps2md_checker
// Port-level checks of the PS/2 mouse decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2md_checker
    import ps2md_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // a fresh result needs a byte taken in through the input register before it
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a byte behind it");

    // y delta is a negated 9-bit value, so -256 never shows; pad stays zero
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:12] != 10'h300) && (m_tdata[47:46] == 2'b00))
        else $error("result fields out of range");

endmodule

bind ps2_mouse_decoder_with_cursor ps2md_checker u_ps2md_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
